### sv/longest_common_subsequence_length_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest common subsequence length block
// Shared clocking and reset gating for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LONGEST_COMMON_SUBSEQUENCE_LENGTH_MACROS_SVH
`define LONGEST_COMMON_SUBSEQUENCE_LENGTH_MACROS_SVH

// Check that a condition holds at every clock edge out of reset.
`define LCSL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LCSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/lcsl_pkg.sv
// ----------------------------------------------------------------------------
// LCS length package
// Sizes, operation codes, the token passed along the cell chain, helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package lcsl_pkg;

  localparam int MAX_LEN = 128;
  // Lengths and table values run 0..MAX_LEN.
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  // Addresses run 0..MAX_LEN-1.
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W   = 8;
  localparam int OUT_W   = 8;

  localparam logic [1:0] OP_FIRST   = 2'd0;
  localparam logic [1:0] OP_SECOND  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  // One table row traveling right: symbol of the first string, the new
  // value of the cell to the left and its value from the row above.
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] diag;
  } lcsl_tok_t;

  function automatic logic [OUT_W-1:0] sat_len(input logic [LEN_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'd255) ? 8'hFF : w[OUT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### sv/lcsl_sym_ram.sv
// ----------------------------------------------------------------------------
// LCS length symbol RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsl_sym_ram
  import lcsl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [IDX_W-1:0] waddr_i,
  input  wire logic [SYM_W-1:0] wdata_i,
  input  wire logic [IDX_W-1:0] raddr_i,
  output logic      [SYM_W-1:0] rdata_o
);

  logic [SYM_W-1:0] mem_q [MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### sv/lcsl_cell.sv
// ----------------------------------------------------------------------------
// LCS length chain cell
// Holds one symbol of the second string and its column of the table row.
// ----------------------------------------------------------------------------
`default_nettype none

module lcsl_cell
  import lcsl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             clr_i,
  input  wire logic             ld_i,
  input  wire logic [SYM_W-1:0] ld_sym_i,
  input  wire lcsl_tok_t        tok_i,
  output lcsl_tok_t             tok_o
);

  logic [SYM_W-1:0] sym_q;
  logic [LEN_W-1:0] dp_q;
  logic [LEN_W-1:0] cell_val;
  logic             valid_q;
  logic             last_q;
  logic [SYM_W-1:0] tsym_q;
  logic [LEN_W-1:0] left_q;
  logic [LEN_W-1:0] diag_q;

  always_comb begin
    if (tok_i.sym == sym_q) begin
      cell_val = tok_i.diag + LEN_W'(1);
    end else if (dp_q > tok_i.left) begin
      cell_val = dp_q;
    end else begin
      cell_val = tok_i.left;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      sym_q <= ld_sym_i;
    end
    if (clr_i) begin
      dp_q <= '0;
    end else if (tok_i.valid) begin
      dp_q <= cell_val;
    end
    last_q <= tok_i.last;
    tsym_q <= tok_i.sym;
    left_q <= cell_val;
    diag_q <= dp_q;
  end

  assign tok_o = '{valid: valid_q, last: last_q, sym: tsym_q, left: left_q, diag: diag_q};

endmodule

`default_nettype wire

### sv/longest_common_subsequence_length.sv
// ----------------------------------------------------------------------------
// Longest common subsequence length
// Timing: a load is written at the transfer; a compute with m, n > 0 streams
//   the first string through n chain cells and registers the result when the
//   last row leaves the last used cell; with an empty string it shows next cycle.
// Throughput: one load per cycle; busy holds off further items during compute.
// Reset: asynchronous, active low; lengths, overflow flag and control clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "longest_common_subsequence_length_macros.svh"

module longest_common_subsequence_length
  import lcsl_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       operation_i,
  input  wire logic [SYM_W-1:0] symbol_i,
  output logic                  result_valid_o,
  output logic      [OUT_W-1:0] lcs_length_o,
  output logic                  overflow_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_FEED = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(MAX_LEN);

  logic [1:0]       state_q, state_d;
  logic [LEN_W-1:0] first_len_q, first_len_d;
  logic [LEN_W-1:0] second_len_q, second_len_d;
  logic             flag_q, flag_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic             feed_valid_q, feed_valid_d;
  logic             feed_last_q, feed_last_d;
  logic             res_valid_q, res_valid_d;
  logic [OUT_W-1:0] res_len_q, res_len_d;
  logic             res_ovf_q, res_ovf_d;

  logic             accept;
  logic             ram_we;
  logic             cell_ld_en;
  logic             cell_clr;
  logic             rd_last;
  logic [SYM_W-1:0] ram_rdata;
  lcsl_tok_t        tok [MAX_LEN+1];
  lcsl_tok_t        tail;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  // Last address of the first string reached in this feed cycle.
  assign rd_last = ((LEN_W'(rd_idx_q) + LEN_W'(1)) == first_len_q);

  // The result is the column of the last symbol of the second string.
  assign tail = tok[second_len_q];

  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    flag_d       = flag_q;
    rd_idx_d     = rd_idx_q;
    feed_valid_d = 1'b0;
    feed_last_d  = 1'b0;
    res_valid_d  = 1'b0;
    res_len_d    = res_len_q;
    res_ovf_d    = res_ovf_q;
    ram_we       = 1'b0;
    cell_ld_en   = 1'b0;
    cell_clr     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_FIRST: begin
              // Append, or drop the symbol and flag it when full.
              if (first_len_q != FULL_LEN) begin
                ram_we      = 1'b1;
                first_len_d = first_len_q + LEN_W'(1);
              end else begin
                flag_d = 1'b1;
              end
            end
            OP_SECOND: begin
              if (second_len_q != FULL_LEN) begin
                cell_ld_en   = 1'b1;
                second_len_d = second_len_q + LEN_W'(1);
              end else begin
                flag_d = 1'b1;
              end
            end
            OP_COMPUTE: begin
              // Zero the table row and kill stale tokens in the chain.
              cell_clr = 1'b1;
              if ((first_len_q == '0) || (second_len_q == '0)) begin
                res_valid_d  = 1'b1;
                res_len_d    = '0;
                res_ovf_d    = flag_q;
                first_len_d  = '0;
                second_len_d = '0;
                flag_d       = 1'b0;
              end else begin
                rd_idx_d = '0;
                state_d  = ST_FEED;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_FEED: begin
        // Stream one symbol of the first string per cycle into the chain.
        feed_valid_d = 1'b1;
        feed_last_d  = rd_last;
        rd_idx_d     = rd_idx_q + IDX_W'(1);
        if (rd_last) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        // Wait for the last row to leave the last used cell.
        if (tail.valid && tail.last) begin
          res_valid_d  = 1'b1;
          res_len_d    = sat_len(tail.left);
          res_ovf_d    = flag_q;
          first_len_d  = '0;
          second_len_d = '0;
          flag_d       = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      first_len_q  <= '0;
      second_len_q <= '0;
      flag_q       <= 1'b0;
      feed_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      flag_q       <= flag_d;
      feed_valid_q <= feed_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q    <= rd_idx_d;
    feed_last_q <= feed_last_d;
    res_len_q   <= res_len_d;
    res_ovf_q   <= res_ovf_d;
  end

  // First string store; read data lines up with feed_valid_q.
  lcsl_sym_ram u_first_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (first_len_q[IDX_W-1:0]),
    .wdata_i (symbol_i),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

  // Column zero of the table is all zero.
  assign tok[0] = '{valid: feed_valid_q, last: feed_last_q, sym: ram_rdata,
                    left: '0, diag: '0};

  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    logic ld;
    assign ld = cell_ld_en && (second_len_q == LEN_W'(j));

    lcsl_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .clr_i    (cell_clr),
      .ld_i     (ld),
      .ld_sym_i (symbol_i),
      .tok_i    (tok[j]),
      .tok_o    (tok[j+1])
    );
  end

  assign result_valid_o = res_valid_q;
  assign lcs_length_o   = res_len_q;
  assign overflow_o     = res_ovf_q;

  `LCSL_ASSERT_IMP(a_result_idle, result_valid_o, state_q == ST_IDLE, "result outside idle")
  `LCSL_ASSERT(a_len_bound, (first_len_q <= FULL_LEN) && (second_len_q <= FULL_LEN), "length overrun")
  `LCSL_ASSERT_IMP(a_feed_nonempty, state_q == ST_FEED, (first_len_q != '0) && (second_len_q != '0), "feed with empty string")

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Longest common subsequence length testbench
// Drive load, compute and unused-code transfers into the block and predict
// every result from a mirror of both strings and the dropped-symbol flag.
// Check each result strobe field by field against the oldest prediction.
// Run directed corner cases, full-string cases and random traffic with the
// sender pausing at several rates.
// ----------------------------------------------------------------------------
module testbench;
  import lcsl_pkg::*;

  // The only operation code the package leaves out: the block ignores it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // A compute over two full strings, the sender's longest pause and a full
  // drain all stay well below this bound.
  localparam int WATCHDOG_LIMIT = 8 * MAX_LEN + 2000;
  localparam int SETTLE_CYCLES  = 2 * MAX_LEN + 8;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [OUT_W-1:0] lcs_length;
    logic             overflow;
  } lcs_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       operation_i;
  logic [SYM_W-1:0] symbol_i;
  logic             result_valid_o;
  logic [OUT_W-1:0] lcs_length_o;
  logic             overflow_o;

  longest_common_subsequence_length dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .symbol_i      (symbol_i),
    .result_valid_o(result_valid_o),
    .lcs_length_o  (lcs_length_o),
    .overflow_o    (overflow_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mirror of the block's strings and flag, updated at each accepted transfer.
  logic [SYM_W-1:0] first_syms  [MAX_LEN];
  logic [SYM_W-1:0] second_syms [MAX_LEN];
  int               first_len;
  int               second_len;
  logic             symbol_dropped;

  // Predicted results, oldest first.
  lcs_result_t      pending_lengths [$];

  int               failures;
  int               items_sent;
  int               gap_pct;
  int               quiet_cycles;

  // Symbol pool for the current sequence; an empty pool means any byte.
  logic [SYM_W-1:0] alphabet [4];
  int               alphabet_size;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Run the table recurrence one row at a time over the mirrored strings.
  // An empty first string leaves the row at zero; an empty second string
  // reads column zero, which is always zero.
  function automatic int lcs_of_mirror();
    int row [MAX_LEN+1];
    int diag;
    int up;
    int val;
    for (int j = 0; j <= MAX_LEN; j++) row[j] = 0;
    for (int i = 0; i < first_len; i++) begin
      diag = 0;
      for (int j = 1; j <= second_len; j++) begin
        up = row[j];
        if (first_syms[i] == second_syms[j-1]) begin
          val = diag + 1;
        end else begin
          val = (up > row[j-1]) ? up : row[j-1];
        end
        diag = up;
        row[j] = val;
      end
    end
    return row[second_len];
  endfunction

  // Apply one accepted transfer to the mirror; a compute queues its result
  // and clears both strings and the flag.
  task automatic apply_transfer(input logic [1:0] op, input logic [SYM_W-1:0] sym);
    lcs_result_t want;
    int          len;
    case (op)
      OP_FIRST: begin
        if (first_len < MAX_LEN) begin
          first_syms[first_len] = sym;
          first_len++;
        end else begin
          symbol_dropped = 1'b1;
        end
      end
      OP_SECOND: begin
        if (second_len < MAX_LEN) begin
          second_syms[second_len] = sym;
          second_len++;
        end else begin
          symbol_dropped = 1'b1;
        end
      end
      OP_COMPUTE: begin
        len = lcs_of_mirror();
        // Saturate to the field width, which only matters for wide strings.
        want.lcs_length = (len > 255) ? '1 : OUT_W'(len);
        want.overflow = symbol_dropped;
        pending_lengths.push_back(want);
        first_len = 0;
        second_len = 0;
        symbol_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // Results stay up for one cycle only, so sample every rising edge and
  // compare against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    lcs_result_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_lengths.size() == 0) begin
        report_failure($sformatf("unexpected result lcs_length=%0d overflow=%0b",
                                 lcs_length_o, overflow_o));
      end else begin
        want = pending_lengths.pop_front();
        if (lcs_length_o !== want.lcs_length) begin
          report_failure($sformatf("lcs_length expected %0d got %0d",
                                   want.lcs_length, lcs_length_o));
        end
        if (overflow_o !== want.overflow) begin
          report_failure($sformatf("overflow expected %0b got %0b",
                                   want.overflow, overflow_o));
        end
      end
    end
  end

  // Count cycles with no transfer on either side; give up on a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Send one item: idle first at the current rate, then hold start until
  // the block takes the transfer at a rising edge with busy low.
  task automatic send_item(input logic [1:0] op, input logic [SYM_W-1:0] sym);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      operation_i <= 2'($urandom_range(3));
      symbol_i <= SYM_W'($urandom_range(255));
    end
    @(negedge clk_i);
    start <= 1'b1;
    operation_i <= op;
    symbol_i <= sym;
    do @(posedge clk_i); while (busy);
    apply_transfer(op, sym);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop start and hold off until every predicted result has arrived.
  task automatic wait_for_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_lengths.size() != 0) @(posedge clk_i);
  endtask

  // Pick a fresh pool of one to four symbols, or none for any byte; small
  // pools make matches common so the table values grow.
  task automatic pick_alphabet();
    alphabet_size = $urandom_range(4);
    foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom_range(255));
  endtask

  function automatic logic [SYM_W-1:0] pick_symbol();
    if (alphabet_size == 0) return SYM_W'($urandom_range(255));
    return alphabet[$urandom_range(alphabet_size - 1)];
  endfunction

  // Load m symbols into the first string and n into the second, mixed in
  // random order, with an unused code thrown in now and then.
  task automatic load_strings(input int m, input int n);
    while (m > 0 || n > 0) begin
      if ($urandom_range(15) == 0) send_item(OP_UNUSED, pick_symbol());
      if (n == 0 || (m > 0 && $urandom_range(1) == 1)) begin
        send_item(OP_FIRST, pick_symbol());
        m--;
      end else begin
        send_item(OP_SECOND, pick_symbol());
        n--;
      end
    end
  endtask

  // Mostly short strings; now and then one of up to half the capacity.
  function automatic int pick_length();
    if ($urandom_range(15) == 0) return $urandom_range(MAX_LEN / 2);
    return $urandom_range(12);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: empty strings, one empty string, the unused code, extreme
  // symbol values and a single-symbol match.
  task automatic test_directed();
    // Both strings empty.
    send_item(OP_COMPUTE, 8'hFF);
    // Unused code changes nothing, even between loads.
    send_item(OP_UNUSED, 8'hFF);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_FIRST, 8'h00);
    send_item(OP_UNUSED, 8'hA5);
    send_item(OP_SECOND, 8'h00);
    send_item(OP_COMPUTE, 8'h5A);
    // Only the first string loaded, then only the second.
    send_item(OP_FIRST, 8'hFF);
    send_item(OP_COMPUTE, 8'h00);
    send_item(OP_SECOND, 8'hFF);
    send_item(OP_COMPUTE, 8'hFF);
    // Extreme symbols in crossed order.
    send_item(OP_FIRST, 8'h00);
    send_item(OP_FIRST, 8'hFF);
    send_item(OP_FIRST, 8'h80);
    send_item(OP_FIRST, 8'h7F);
    send_item(OP_SECOND, 8'hFF);
    send_item(OP_SECOND, 8'h00);
    send_item(OP_SECOND, 8'h7F);
    send_item(OP_COMPUTE, 8'h00);
    // Symbols differing in every bit never match.
    send_item(OP_FIRST, 8'h55);
    send_item(OP_SECOND, 8'hAA);
    send_item(OP_COMPUTE, 8'h00);
  endtask

  // Fill strings to capacity and past it: identical full strings with two
  // extra symbols, an exact fit, and an overflow on the second string alone.
  task automatic test_full_strings();
    logic [SYM_W-1:0] pattern [MAX_LEN];
    pick_alphabet();
    foreach (pattern[k]) pattern[k] = pick_symbol();
    for (int k = 0; k < MAX_LEN; k++) send_item(OP_SECOND, pattern[k]);
    for (int k = 0; k < MAX_LEN; k++) send_item(OP_FIRST, pattern[k]);
    send_item(OP_FIRST, pick_symbol());
    send_item(OP_FIRST, pick_symbol());
    send_item(OP_COMPUTE, pick_symbol());
    load_strings(MAX_LEN, 1);
    send_item(OP_COMPUTE, pick_symbol());
    load_strings(3, MAX_LEN + 1);
    send_item(OP_COMPUTE, pick_symbol());
  endtask

  // Random traffic: mostly well-formed load-then-compute sequences, some
  // short runs of random codes of any kind, some lone computes.
  task automatic test_random_traffic(input int goal);
    int stop_at;
    int kind;
    stop_at = items_sent + goal;
    while (items_sent < stop_at) begin
      kind = $urandom_range(99);
      pick_alphabet();
      if (kind < 80) begin
        load_strings(pick_length(), pick_length());
        send_item(OP_COMPUTE, SYM_W'($urandom_range(255)));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 4)) begin
          send_item(2'($urandom_range(OP_UNUSED)), pick_symbol());
        end
      end else begin
        send_item(OP_COMPUTE, SYM_W'($urandom_range(255)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    operation_i = OP_FIRST;
    symbol_i = '0;
    first_len = 0;
    second_len = 0;
    symbol_dropped = 1'b0;
    failures = 0;
    items_sent = 0;
    gap_pct = 0;
    alphabet_size = 0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();

    // Sender idles often at first.
    gap_pct = 25;
    test_random_traffic(240);
    test_full_strings();

    // Hold off until the block drains, then idle most of the time.
    wait_for_results();
    gap_pct = 85;
    test_random_traffic(240);

    // Drain again, then send back to back.
    wait_for_results();
    gap_pct = 0;
    test_random_traffic(240);

    // Wait for the last results and leave time for any stray strobe.
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pending_lengths.size() != 0) begin
      report_failure($sformatf("%0d results never arrived", pending_lengths.size()));
    end

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+sv
sv/lcsl_pkg.sv
sv/lcsl_sym_ram.sv
sv/lcsl_cell.sv
sv/longest_common_subsequence_length.sv
tb/testbench.sv
